>>> hdl/tcrr_pkg.sv
// -----------------------------------------------------------------------------
// tcrr_pkg
// Shared widths, register indexes, phase codes and the command/status
// bundles between the scheduler controller and its datapath.
// -----------------------------------------------------------------------------
package tcrr_pkg;

   // Field widths
   localparam int MASK_W      = 8;   // alive mask per class
   localparam int LIVE_W      = 4;   // live count
   localparam int BASE_W      = 13;  // descriptor table index
   localparam int TPR_W       = 4;   // tasks per round
   localparam int SEL_W       = 16;  // descriptor selector
   localparam int SEL_SHIFT   = 3;   // selector = index << 3
   localparam int SLOT_W      = 3;   // reported slot
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 2;

   // Register reset values
   localparam logic [TPR_W-1:0] TPR_RESET = TPR_W'(3);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TASK_BASE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FLAG_BASE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TASKS_PER_ROUND = 2'd2;

   // Scheduling phase
   typedef enum logic [1:0] {
      PH_TASK = 2'b01,
      PH_FLAG = 2'b10
   } phase_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture a grant into the result register
      logic live_zero;  // tick with zero live count: no grant, no pointer move
      logic use_flag;   // grant from the flag-handler class
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [TPR_W-1:0] tasks_per_round;
   } dp_sts_type;

endpackage

>>> hdl/tcrr_ctrl.sv
// -----------------------------------------------------------------------------
// tcrr_ctrl
// Phase controller: tracks task/flag phase and grant counts, decides which
// class each accepted transaction is granted from, and runs the handshake.
// -----------------------------------------------------------------------------
module tcrr_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [tcrr_pkg::LIVE_W-1:0]  live_count,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  tcrr_pkg::dp_sts_type         sts,
   output tcrr_pkg::ctl_cmd_type        cmd
);

   tcrr_pkg::phase_state_type         phase_ff, phase_in;
   logic [tcrr_pkg::TPR_W-1:0]        task_grants_ff, task_grants_in;
   logic [tcrr_pkg::LIVE_W-1:0]       flag_grants_ff, flag_grants_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              accept;
   logic                              live_zero;
   logic                              use_flag;
   logic [tcrr_pkg::LIVE_W:0]         flag_next;

   // Take a new transaction when the result register is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign live_zero  = (live_count == '0);
   assign flag_next  = {1'b0, flag_grants_ff} + (tcrr_pkg::LIVE_W+1)'(1);

   // Decide the class and next phase/counters
   always_comb begin
      phase_in       = phase_ff;
      task_grants_in = task_grants_ff;
      flag_grants_in = flag_grants_ff;
      use_flag       = 1'b0;
      unique case (phase_ff)
         tcrr_pkg::PH_TASK: begin
            if (task_grants_ff >= sts.tasks_per_round) begin
               phase_in       = tcrr_pkg::PH_FLAG;
               task_grants_in = '0;
               use_flag       = 1'b1;
            end else begin
               task_grants_in = task_grants_ff + tcrr_pkg::TPR_W'(1);
            end
         end
         tcrr_pkg::PH_FLAG: begin
            if (flag_next >= {1'b0, live_count}) begin
               phase_in       = tcrr_pkg::PH_TASK;
               flag_grants_in = '0;
            end else begin
               flag_grants_in = flag_next[tcrr_pkg::LIVE_W-1:0];
               use_flag       = 1'b1;
            end
         end
         default: begin
            phase_in = tcrr_pkg::PH_TASK;
         end
      endcase
   end

   // Hold the result until the downstream side takes it
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Advance phase state only on an accepted transaction with a nonzero live count
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= tcrr_pkg::PH_TASK;
         task_grants_ff <= '0;
         flag_grants_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept && !live_zero) begin
            phase_ff       <= phase_in;
            task_grants_ff <= task_grants_in;
            flag_grants_ff <= flag_grants_in;
         end
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign cmd.load      = accept;
   assign cmd.live_zero = live_zero;
   assign cmd.use_flag  = use_flag && !live_zero;

endmodule

>>> hdl/tcrr_dpath.sv
// -----------------------------------------------------------------------------
// tcrr_dpath
// Datapath: configuration registers, per-class round-robin pointers, one
// shared rotating priority encoder, selector arithmetic and result register.
// -----------------------------------------------------------------------------
module tcrr_dpath #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tcrr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcrr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [tcrr_pkg::MASK_W-1:0]      task_alive,
   input  logic [tcrr_pkg::MASK_W-1:0]      flag_alive,
   input  tcrr_pkg::ctl_cmd_type            cmd,
   output tcrr_pkg::dp_sts_type             sts,
   output logic [tcrr_pkg::SEL_W-1:0]       selector,
   output logic [tcrr_pkg::SLOT_W-1:0]      slot,
   output logic                             is_flag,
   output logic                             none_alive
);

   localparam int PTR_W = $clog2(NUM_SLOTS);
   localparam logic [PTR_W-1:0] PTR_RESET = PTR_W'(NUM_SLOTS - 1);

   logic [tcrr_pkg::BASE_W-1:0]  task_base_ff;
   logic [tcrr_pkg::BASE_W-1:0]  flag_base_ff;
   logic [tcrr_pkg::TPR_W-1:0]   tpr_ff;
   logic [PTR_W-1:0]             task_ptr_ff;
   logic [PTR_W-1:0]             flag_ptr_ff;

   logic [tcrr_pkg::MASK_W-1:0]  cls_mask;
   logic [PTR_W-1:0]             cls_ptr;
   logic [tcrr_pkg::BASE_W-1:0]  cls_base;
   logic [NUM_SLOTS-1:0]         mask_ext;
   logic [NUM_SLOTS-1:0]         above_ptr;
   logic [NUM_SLOTS-1:0]         pick_mask;
   logic [PTR_W-1:0]             pick_slot;
   logic                         found;
   logic [tcrr_pkg::BASE_W-1:0]  index_sum;

   logic [tcrr_pkg::SEL_W-1:0]   selector_ff;
   logic [tcrr_pkg::SLOT_W-1:0]  slot_ff;
   logic                         is_flag_ff;
   logic                         none_alive_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_base_ff <= '0;
         flag_base_ff <= '0;
         tpr_ff       <= tcrr_pkg::TPR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tcrr_pkg::REG_TASK_BASE:       task_base_ff <= csr_wdata;
            tcrr_pkg::REG_FLAG_BASE:       flag_base_ff <= csr_wdata;
            tcrr_pkg::REG_TASKS_PER_ROUND: tpr_ff <= csr_wdata[tcrr_pkg::TPR_W-1:0];
            default: ;
         endcase
      end
   end

   assign sts.tasks_per_round = tpr_ff;

   // Select the class being served
   assign cls_mask = cmd.use_flag ? flag_alive   : task_alive;
   assign cls_ptr  = cmd.use_flag ? flag_ptr_ff  : task_ptr_ff;
   assign cls_base = cmd.use_flag ? flag_base_ff : task_base_ff;

   // Slots beyond the mask width are never alive
   assign mask_ext = NUM_SLOTS'(cls_mask);

   // Rotating priority: first alive slot above the pointer, else wrap around
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         above_ptr[i] = (PTR_W'(i) > cls_ptr);
      end
   end

   assign pick_mask = (|(mask_ext & above_ptr)) ? (mask_ext & above_ptr) : mask_ext;
   assign found     = |mask_ext;

   // Lowest set bit of the chosen window
   always_comb begin
      pick_slot = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (pick_mask[i]) begin
            pick_slot = PTR_W'(i);
         end
      end
   end

   assign index_sum = cls_base + tcrr_pkg::BASE_W'(pick_slot);

   // Move the served class pointer to the granted slot
   always_ff @(posedge clock) begin
      if (reset) begin
         task_ptr_ff <= PTR_RESET;
         flag_ptr_ff <= PTR_RESET;
      end else if (cmd.load && !cmd.live_zero && found) begin
         if (cmd.use_flag) begin
            flag_ptr_ff <= pick_slot;
         end else begin
            task_ptr_ff <= pick_slot;
         end
      end
   end

   // Capture the grant
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_flag_ff <= cmd.use_flag;
         if (cmd.live_zero || !found) begin
            selector_ff   <= '0;
            slot_ff       <= '0;
            none_alive_ff <= 1'b1;
         end else begin
            selector_ff   <= {index_sum, tcrr_pkg::SEL_SHIFT'(0)};
            slot_ff       <= tcrr_pkg::SLOT_W'(pick_slot);
            none_alive_ff <= 1'b0;
         end
      end
   end

   assign selector   = selector_ff;
   assign slot       = slot_ff;
   assign is_flag    = is_flag_ff;
   assign none_alive = none_alive_ff;

endmodule

>>> hdl/two_class_round_robin_scheduler.sv
// -----------------------------------------------------------------------------
// two_class_round_robin_scheduler
// Grants at most one task or flag-handler slot per scheduling tick, alternating a
// task phase and a flag phase with separate round-robin pointers per class.
// -----------------------------------------------------------------------------
// Each request transaction is one scheduling tick and produces exactly one
// response transaction. The block takes one tick per clock cycle while the
// response register is free or being drained: a tick is resolved in the
// cycle it is accepted by a single rotating priority encoder shared by both
// classes, and its grant lands in the response register on that edge. A new
// request is taken whenever the response register is empty or is being taken
// in the same cycle, so with rsp_tready held high the throughput is one grant
// per cycle. Configuration writes take effect on the next edge and should be
// made while no tick is in flight.
module two_class_round_robin_scheduler #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] task_alive, [15:8] flag_alive, [19:16] live_count
   input  logic [tcrr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] selector, [18:16] slot
   output logic [tcrr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [0] is_flag, [1] none_alive
   output logic [tcrr_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   // configuration write port
   input  logic                              csr_we,
   input  logic [tcrr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcrr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   tcrr_pkg::ctl_cmd_type              cmd;
   tcrr_pkg::dp_sts_type               sts;
   logic [tcrr_pkg::MASK_W-1:0]        task_alive;
   logic [tcrr_pkg::MASK_W-1:0]        flag_alive;
   logic [tcrr_pkg::LIVE_W-1:0]        live_count;
   logic [tcrr_pkg::SEL_W-1:0]         selector;
   logic [tcrr_pkg::SLOT_W-1:0]        slot;
   logic                               is_flag;
   logic                               none_alive;

   // Unpack the request fields
   assign task_alive = req_tdata[7:0];
   assign flag_alive = req_tdata[15:8];
   assign live_count = req_tdata[19:16];

   tcrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .live_count (live_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tcrr_dpath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .task_alive (task_alive),
      .flag_alive (flag_alive),
      .cmd        (cmd),
      .sts        (sts),
      .selector   (selector),
      .slot       (slot),
      .is_flag    (is_flag),
      .none_alive (none_alive)
   );

   // Pack the response fields
   assign rsp_tdata = {5'b0, slot, selector};
   assign rsp_tuser = {none_alive, is_flag};

endmodule

>>> bench/tb_two_class_round_robin_scheduler.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_two_class_round_robin_scheduler
// Self-checking bench for the two-class round-robin scheduler.
// -----------------------------------------------------------------------------
// A queue of scheduling ticks feeds a clocked stream driver. A clocked
// monitor sees each accepted tick, runs it through a cycle-free model of
// the phase counters and per-class pointers, and compares every response
// transaction with the oldest predicted grant. The run starts with directed
// ticks (zero live count, empty masks, single slots, shortest and longest
// phases), then random batches, each under its own register setting and
// its own amount of random idling on the request and response sides.
module tb_two_class_round_robin_scheduler;

   localparam int WATCHDOG_LIMIT = 500;
   localparam int RANDOM_BATCHES = 9;
   localparam int BATCH_TICKS    = 50;
   localparam logic [tcrr_pkg::BASE_W-1:0] BASE_MAX = tcrr_pkg::BASE_W'(8184);

   typedef struct packed {
      logic [tcrr_pkg::LIVE_W-1:0] live_count;
      logic [tcrr_pkg::MASK_W-1:0] flag_alive;
      logic [tcrr_pkg::MASK_W-1:0] task_alive;
   } sched_tick_type;

   typedef struct packed {
      logic [tcrr_pkg::SEL_W-1:0]  selector;
      logic                        is_flag;
      logic [tcrr_pkg::SLOT_W-1:0] slot;
      logic                        none_alive;
   } grant_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [tcrr_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [tcrr_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [tcrr_pkg::RSP_TUSER_W-1:0] rsp_tuser;
   logic                             csr_we     = 1'b0;
   logic [tcrr_pkg::CSR_IDX_W-1:0]   csr_index  = '0;
   logic [tcrr_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Mirror of the block's registers and scheduling state
   logic [tcrr_pkg::BASE_W-1:0] task_base_cfg = '0;
   logic [tcrr_pkg::BASE_W-1:0] flag_base_cfg = '0;
   logic [tcrr_pkg::TPR_W-1:0]  tasks_per_round_cfg = tcrr_pkg::TPR_RESET;
   tcrr_pkg::phase_state_type   sched_phase = tcrr_pkg::PH_TASK;
   logic [3:0]                  task_grant_cnt = '0;
   logic [3:0]                  flag_grant_cnt = '0;
   logic [2:0]                  task_ptr = 3'd7;
   logic [2:0]                  flag_ptr = 3'd7;

   sched_tick_type pending_ticks[$];
   grant_type      expected_grants[$];
   sched_tick_type drv_tick;
   sched_tick_type seen_tick;
   grant_type      want_grant;
   grant_type      got_grant;

   int req_gap      = 0;
   int rsp_stall    = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int quiet_cycles = 0;
   int error_count  = 0;
   int tick_count   = 0;
   int task_grants_seen = 0;
   int flag_grants_seen = 0;
   int empty_grants_seen = 0;
   int setting_count = 0;

   two_class_round_robin_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Search the slots after ptr, wrapping; returns {found, slot}
   function automatic logic [3:0] find_next_alive(
      input logic [2:0]                  ptr,
      input logic [tcrr_pkg::MASK_W-1:0] mask
   );
      logic       found;
      logic [2:0] cand;
      logic [2:0] hit;
      found = 1'b0;
      hit   = '0;
      for (int k = 1; k <= tcrr_pkg::MASK_W; k++) begin
         cand = ptr + 3'(k);
         if (!found && mask[cand]) begin
            found = 1'b1;
            hit   = cand;
         end
      end
      return {found, hit};
   endfunction

   // Grant from one class and move that class's pointer
   function automatic grant_type grant_class(input logic use_flag,
                                             input sched_tick_type t);
      grant_type                   g;
      logic [3:0]                  res;
      logic [tcrr_pkg::BASE_W-1:0] base;
      logic [tcrr_pkg::SEL_W-1:0]  index;
      g = '0;
      g.is_flag = use_flag;
      if (use_flag) begin
         res  = find_next_alive(flag_ptr, t.flag_alive);
         base = flag_base_cfg;
         if (res[3]) flag_ptr = res[2:0];
      end else begin
         res  = find_next_alive(task_ptr, t.task_alive);
         base = task_base_cfg;
         if (res[3]) task_ptr = res[2:0];
      end
      if (res[3]) begin
         index      = tcrr_pkg::SEL_W'(base) + tcrr_pkg::SEL_W'(res[2:0]);
         g.selector = index << tcrr_pkg::SEL_SHIFT;
         g.slot     = res[2:0];
      end else begin
         g.none_alive = 1'b1;
      end
      return g;
   endfunction

   // Advance the phase counters for one tick and return its grant
   function automatic grant_type schedule_tick(input sched_tick_type t);
      grant_type  g;
      logic [4:0] next_flag;
      g = '0;
      if (t.live_count == '0) begin
         g.none_alive = 1'b1;
      end else if (sched_phase == tcrr_pkg::PH_TASK) begin
         if (task_grant_cnt >= tasks_per_round_cfg) begin
            sched_phase    = tcrr_pkg::PH_FLAG;
            task_grant_cnt = '0;
            g = grant_class(1'b1, t);
         end else begin
            task_grant_cnt = task_grant_cnt + 4'd1;
            g = grant_class(1'b0, t);
         end
      end else begin
         next_flag = 5'(flag_grant_cnt) + 5'd1;
         if (next_flag >= 5'(t.live_count)) begin
            sched_phase    = tcrr_pkg::PH_TASK;
            flag_grant_cnt = '0;
            g = grant_class(1'b0, t);
         end else begin
            flag_grant_cnt = next_flag[3:0];
            g = grant_class(1'b1, t);
         end
      end
      return g;
   endfunction

   // Request driver: hold each tick until accepted, insert idle bursts
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_ticks.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (req_idle_pct != 0 && $urandom_range(99, 0) < req_idle_pct) begin
            req_gap = $urandom_range(14, 0);
            req_tvalid <= 1'b0;
         end else begin
            drv_tick = pending_ticks.pop_front();
            req_tdata  <= tcrr_pkg::REQ_TDATA_W'(drv_tick);
            req_tvalid <= 1'b1;
         end
      end
   end

   // Monitor: predict on each accepted tick, check each response transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            seen_tick = sched_tick_type'(req_tdata[$bits(sched_tick_type)-1:0]);
            want_grant = schedule_tick(seen_tick);
            expected_grants.push_back(want_grant);
            tick_count++;
            if (want_grant.none_alive) empty_grants_seen++;
            else if (want_grant.is_flag) flag_grants_seen++;
            else task_grants_seen++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_grant.selector   = rsp_tdata[tcrr_pkg::SEL_W-1:0];
            got_grant.slot       = rsp_tdata[tcrr_pkg::SEL_W +: tcrr_pkg::SLOT_W];
            got_grant.is_flag    = rsp_tuser[0];
            got_grant.none_alive = rsp_tuser[1];
            if (expected_grants.size() == 0) begin
               error_count++;
               $write("%0t: unexpected grant: expected none,", $time);
               $display(" actual sel=%h flag=%0b slot=%0d none=%0b",
                        got_grant.selector, got_grant.is_flag, got_grant.slot,
                        got_grant.none_alive);
            end else begin
               want_grant = expected_grants.pop_front();
               if (got_grant.selector !== want_grant.selector ||
                   got_grant.is_flag !== want_grant.is_flag ||
                   got_grant.slot !== want_grant.slot ||
                   got_grant.none_alive !== want_grant.none_alive) begin
                  error_count++;
                  $write("%0t: grant mismatch: expected sel=%h flag=%0b slot=%0d none=%0b",
                         $time, want_grant.selector, want_grant.is_flag,
                         want_grant.slot, want_grant.none_alive);
                  $display(", actual sel=%h flag=%0b slot=%0d none=%0b",
                           got_grant.selector, got_grant.is_flag,
                           got_grant.slot, got_grant.none_alive);
               end
            end
         end
         // Response back-pressure in random bursts
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_pct != 0 && $urandom_range(99, 0) < rsp_idle_pct) begin
            rsp_stall = $urandom_range(14, 0);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic csr_write(input logic [tcrr_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [tcrr_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         tcrr_pkg::REG_TASK_BASE:       task_base_cfg = val[tcrr_pkg::BASE_W-1:0];
         tcrr_pkg::REG_FLAG_BASE:       flag_base_cfg = val[tcrr_pkg::BASE_W-1:0];
         tcrr_pkg::REG_TASKS_PER_ROUND: tasks_per_round_cfg = val[tcrr_pkg::TPR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [tcrr_pkg::BASE_W-1:0] tb,
                             input logic [tcrr_pkg::BASE_W-1:0] fb,
                             input logic [tcrr_pkg::TPR_W-1:0]  tpr);
      csr_write(tcrr_pkg::REG_TASK_BASE, tcrr_pkg::CSR_DATA_W'(tb));
      csr_write(tcrr_pkg::REG_FLAG_BASE, tcrr_pkg::CSR_DATA_W'(fb));
      csr_write(tcrr_pkg::REG_TASKS_PER_ROUND, tcrr_pkg::CSR_DATA_W'(tpr));
      setting_count++;
   endtask

   task automatic queue_tick(input logic [tcrr_pkg::MASK_W-1:0] ta,
                             input logic [tcrr_pkg::MASK_W-1:0] fa,
                             input logic [tcrr_pkg::LIVE_W-1:0] lc);
      sched_tick_type t;
      t.task_alive = ta;
      t.flag_alive = fa;
      t.live_count = lc;
      pending_ticks.push_back(t);
   endtask

   // Wait until every tick is sent and every grant has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || expected_grants.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   function automatic logic [tcrr_pkg::BASE_W-1:0] rand_base();
      case ($urandom_range(3, 0))
         0:       return '0;
         1:       return BASE_MAX;
         default: return tcrr_pkg::BASE_W'($urandom_range(8184, 0));
      endcase
   endfunction

   function automatic logic [tcrr_pkg::TPR_W-1:0] rand_tpr();
      case ($urandom_range(3, 0))
         0:       return tcrr_pkg::TPR_W'(1);
         1:       return tcrr_pkg::TPR_W'(15);
         default: return tcrr_pkg::TPR_W'($urandom_range(15, 1));
      endcase
   endfunction

   function automatic logic [tcrr_pkg::MASK_W-1:0] rand_mask();
      case ($urandom_range(9, 0))
         0:       return '0;
         1:       return '1;
         2:       return tcrr_pkg::MASK_W'(1) << $urandom_range(tcrr_pkg::MASK_W - 1, 0);
         default: return tcrr_pkg::MASK_W'($urandom);
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(2, 0))
         0:       return 0;
         1:       return 10;
         default: return 35;
      endcase
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset values of the registers: zero live count, full, empty and
      // single-slot masks, flag phases of length one and eight
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      setting_count = 1;
      queue_tick(8'hFF, 8'hFF, 4'd0);
      queue_tick(8'hFF, 8'hFF, 4'd8);
      queue_tick(8'h01, 8'h80, 4'd8);
      queue_tick(8'h00, 8'hFF, 4'd2);
      queue_tick(8'hFF, 8'h00, 4'd2);
      queue_tick(8'h80, 8'h01, 4'd1);
      queue_tick(8'hAA, 8'h55, 4'd1);
      queue_tick(8'h55, 8'hAA, 4'd8);
      queue_tick(8'hFF, 8'hFF, 4'd3);
      queue_tick(8'h00, 8'h00, 4'd4);
      wait_drained();

      // Highest bases and the longest task phase
      set_config(BASE_MAX, BASE_MAX, tcrr_pkg::TPR_W'(15));
      repeat (6) queue_tick(8'hFF, 8'hFF, 4'd8);
      wait_drained();

      // Zero tasks per round: every task-phase tick switches to flags
      set_config('0, BASE_MAX, tcrr_pkg::TPR_W'(0));
      queue_tick(8'hFF, 8'h81, 4'd2);
      queue_tick(8'h81, 8'hFF, 4'd2);
      queue_tick(8'hFF, 8'hFF, 4'd1);
      queue_tick(8'h7E, 8'h00, 4'd1);
      queue_tick(8'hFF, 8'hFF, 4'd0);
      queue_tick(8'h0F, 8'hF0, 4'd3);
      wait_drained();

      // Random batches, each under a fresh setting; the last one runs
      // without idling
      for (int b = 0; b < RANDOM_BATCHES; b++) begin
         if (b == RANDOM_BATCHES - 1) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = pick_idle_pct();
            rsp_idle_pct = pick_idle_pct();
         end
         set_config(rand_base(), rand_base(), rand_tpr());
         for (int i = 0; i < BATCH_TICKS; i++) begin
            queue_tick(rand_mask(), rand_mask(),
                       ($urandom_range(15, 0) == 0)
                          ? tcrr_pkg::LIVE_W'(0)
                          : tcrr_pkg::LIVE_W'($urandom_range(8, 1)));
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d ticks over %0d register settings:", tick_count, setting_count);
      $display("  %0d task grants, %0d flag grants, %0d with nothing granted",
               task_grants_seen, flag_grants_seen, empty_grants_seen);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
hdl/tcrr_pkg.sv
hdl/tcrr_ctrl.sv
hdl/tcrr_dpath.sv
hdl/two_class_round_robin_scheduler.sv
bench/tb_two_class_round_robin_scheduler.sv
